>>> src/dqs_pkg.sv
package dqs_pkg;

   // Operation codes
   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_POP_FRONT  = 3'd2;
   localparam logic [2:0] OP_POP_BACK   = 3'd3;
   localparam logic [2:0] OP_CONTAINS   = 3'd4;
   localparam logic [2:0] OP_REMOVE     = 3'd5;

   // Status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_MISS  = 2'd3;

   typedef logic signed [31:0] word_type;

   typedef struct packed {
      logic [2:0] operation;
      word_type   value;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      word_type   front_value;
      word_type   back_value;
      logic [4:0] entry_count;
      logic       is_empty;
   } rsp_payload_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic     push_front;
      logic     push_back;
      logic     pop_front;
      logic     remove;
      word_type value;
   } cell_cmd_type;

endpackage

>>> src/dqs_if.sv
interface dqs_req_if;
   import dqs_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface dqs_rsp_if;
   import dqs_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> src/deque_with_value_search.sv
// Double-ended queue with value search, built as a row of DEPTH cells.
// Response is registered: valid in the cycle after the request transfer.
// Throughput: one operation per cycle while no response is stalled; the
// cycle is set by the match and back-value chains rippling through all cells.
// Reset (synchronous) empties the queue and drops any pending response;
// entry storage is not cleared.
module deque_with_value_search #(
   parameter int DEPTH = 16
) (
   input logic      clock,
   input logic      reset,
   dqs_req_if.sink  req_ch,
   dqs_rsp_if.source rsp_ch
);
   import dqs_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic [CW-1:0]   occ_ff;
   logic [CW-1:0]   occ_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type rsp_data_in;

   logic            accept;
   logic            full;
   logic            empty;
   logic            hit;
   logic [2:0]      op;
   cell_cmd_type    cmd;
   logic [31:0]     occ_wide;
   logic [1:0]      status_in;
   logic            found_in;

   word_type        entry_q [DEPTH];
   word_type        next_q  [DEPTH];
   logic            seen_c  [DEPTH+1];
   word_type        back_c  [DEPTH+1];

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign op           = req_ch.data.operation;
   assign full         = (occ_ff == FULL_COUNT);
   assign empty        = (occ_ff == '0);

   // Command broadcast; all command flags low when nothing is transferred
   always_comb begin
      cmd.value      = req_ch.data.value;
      cmd.push_front = accept && (op == OP_PUSH_FRONT) && !full;
      cmd.push_back  = accept && (op == OP_PUSH_BACK) && !full;
      cmd.pop_front  = accept && (op == OP_POP_FRONT) && !empty;
      cmd.remove     = accept && (op == OP_REMOVE);
   end

   // Row of cells
   assign seen_c[0] = 1'b0;
   assign back_c[0] = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      word_type left_v;
      word_type right_v;
      if (i == 0) begin : g_first
         assign left_v = req_ch.data.value;
      end else begin : g_mid_l
         assign left_v = entry_q[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_v = entry_q[i];
      end else begin : g_mid_r
         assign right_v = entry_q[i+1];
      end
      dqs_cell #(.DEPTH(DEPTH), .INDEX(i)) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occ         (occ_ff),
         .occ_next    (occ_in),
         .left_value  (left_v),
         .right_value (right_v),
         .seen_in     (seen_c[i]),
         .back_in     (back_c[i]),
         .entry_value (entry_q[i]),
         .entry_next  (next_q[i]),
         .seen_out    (seen_c[i+1]),
         .back_out    (back_c[i+1])
      );
   end

   assign hit = seen_c[DEPTH];

   // Status, found flag and next occupancy
   always_comb begin
      occ_in    = occ_ff;
      status_in = ST_DONE;
      found_in  = 1'b0;
      unique case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (full) status_in = ST_FULL;
            else      occ_in = occ_ff + CW'(1);
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (empty) status_in = ST_EMPTY;
            else       occ_in = occ_ff - CW'(1);
         end
         OP_CONTAINS: begin
            found_in  = hit;
            status_in = hit ? ST_DONE : ST_MISS;
         end
         OP_REMOVE: begin
            found_in  = hit;
            status_in = hit ? ST_DONE : ST_MISS;
            if (hit) occ_in = occ_ff - CW'(1);
         end
         default: begin
         end
      endcase
      if (!accept) occ_in = occ_ff;
   end

   // Queue view after the step
   assign occ_wide = 32'(occ_in);
   always_comb begin
      rsp_data_in.status      = status_in;
      rsp_data_in.found       = found_in;
      rsp_data_in.front_value = (occ_in != '0) ? next_q[0] : '0;
      rsp_data_in.back_value  = back_c[DEPTH];
      rsp_data_in.entry_count = occ_wide[4:0];
      rsp_data_in.is_empty    = (occ_in == '0);
   end

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ch.ready) rsp_valid_in = 1'b0;
      if (accept)       rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

>>> src/dqs_cell.sv
module dqs_cell #(
   parameter  int DEPTH = 16,
   parameter  int INDEX = 0,
   localparam int CW    = $clog2(DEPTH + 1)
) (
   input  logic                 clock,
   input  dqs_pkg::cell_cmd_type cmd,
   input  logic [CW-1:0]        occ,
   input  logic [CW-1:0]        occ_next,
   input  dqs_pkg::word_type    left_value,
   input  dqs_pkg::word_type    right_value,
   input  logic                 seen_in,
   input  dqs_pkg::word_type    back_in,
   output dqs_pkg::word_type    entry_value,
   output dqs_pkg::word_type    entry_next,
   output logic                 seen_out,
   output dqs_pkg::word_type    back_out
);
   import dqs_pkg::*;

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   word_type entry_ff;
   word_type entry_in;
   logic     match;
   logic     shift;
   logic     is_last;

   // Match only on occupied positions; the chain marks the first hit onwards
   assign match    = (entry_ff == cmd.value) && (IDX < occ);
   assign seen_out = seen_in | match;
   assign shift    = cmd.pop_front | (cmd.remove & seen_out);

   // Next entry value
   always_comb begin
      priority if (cmd.push_front) begin
         entry_in = (INDEX == 0) ? cmd.value : left_value;
      end else if (cmd.push_back && IDX == occ) begin
         entry_in = cmd.value;
      end else if (shift) begin
         entry_in = right_value;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   // Back value: the cell holding the last entry after the step drives the chain
   assign is_last  = (occ_next != '0) && (IDX == occ_next - CW'(1));
   assign back_out = is_last ? (back_in | entry_in) : back_in;

   assign entry_value = entry_ff;
   assign entry_next  = entry_in;

endmodule

>>> src/dqs_checker.sv
module dqs_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input dqs_pkg::rsp_payload_type rsp_data
);
   import dqs_pkg::*;

   // A stalled response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // Every request transfer gives a response in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("no response after request transfer");

   // Empty flag agrees with the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.is_empty == (rsp_data.entry_count == 5'd0)))
      else $error("empty flag and count disagree");

   // A hit always reports done
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> (rsp_data.status == ST_DONE))
      else $error("found set with a failing status");

   // An empty queue shows zero front and back
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |->
         (rsp_data.front_value == '0) && (rsp_data.back_value == '0))
      else $error("empty queue shows nonzero values");

endmodule

bind deque_with_value_search dqs_checker u_dqs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

>>> tb/tb_deque_with_value_search.sv
module tb_deque_with_value_search;
   import dqs_pkg::*;

   localparam int DQ_DEPTH = 16;
   localparam int RANDOM_OPS = 1800;
   localparam int LONG_HOLD_CYCLES = 80;

   // Spare operation codes, decoded by the block as no-ops
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam word_type WORD_MAX = 32'sh7fff_ffff;
   localparam word_type WORD_MIN = 32'sh8000_0000;

   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   // One row of the directed table; a literal response is used where pinned is set
   typedef struct {
      logic [2:0]      op;
      word_type        value;
      int              reps;
      bit              pinned;
      rsp_payload_type lit;
   } stim_row_type;

   typedef struct packed {
      bit              pinned;
      rsp_payload_type rsp;
   } literal_tag_type;

   logic clock;
   logic reset;

   dqs_req_if req_ch ();
   dqs_rsp_if rsp_ch ();

   deque_with_value_search #(.DEPTH(DQ_DEPTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the deque contents, front at index 0
   word_type shadow_entries [DQ_DEPTH];
   int       shadow_held;

   rsp_payload_type predicted_rsp_q [$];
   literal_tag_type literal_rsp_q [$];
   stim_row_type    stim_table [$];

   int  error_count;
   int  rsp_seen;
   int  op_tally [8];
   int  status_tally [4];
   int  full_hits;
   int  rsp_hold;
   bit  quiet_phase;
   bit  long_hold;

   word_type value_pool [8] = '{32'sd0, 32'sd1, -32'sd1, 32'sd7, 32'sd42,
                                WORD_MAX, WORD_MIN, 32'sh55aa_55aa};

   // Clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run limit
   initial begin
      #1600000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Position of the first entry equal to v, or -1
   function automatic int locate_value(word_type v);
      int i;
      for (i = 0; i < shadow_held; i++) begin
         if (shadow_entries[i] === v) return i;
      end
      return -1;
   endfunction

   // Close the gap at pos by shifting later entries one place to the front
   function automatic void close_gap(int pos);
      int i;
      for (i = pos; i + 1 < shadow_held; i++) shadow_entries[i] = shadow_entries[i + 1];
      shadow_held--;
   endfunction

   // Apply one operation to the shadow deque and build the response it gives
   function automatic rsp_payload_type apply_deque_op(logic [2:0] op, word_type v);
      rsp_payload_type r;
      int i;
      int pos;
      r = '0;
      r.status = ST_DONE;
      case (op)
         OP_PUSH_FRONT: begin
            if (shadow_held >= DQ_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               for (i = shadow_held; i > 0; i--) shadow_entries[i] = shadow_entries[i - 1];
               shadow_entries[0] = v;
               shadow_held++;
            end
         end
         OP_PUSH_BACK: begin
            if (shadow_held >= DQ_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               shadow_entries[shadow_held] = v;
               shadow_held++;
            end
         end
         OP_POP_FRONT: begin
            if (shadow_held == 0) r.status = ST_EMPTY;
            else close_gap(0);
         end
         OP_POP_BACK: begin
            if (shadow_held == 0) r.status = ST_EMPTY;
            else shadow_held--;
         end
         OP_CONTAINS: begin
            if (locate_value(v) >= 0) r.found = 1'b1;
            else r.status = ST_MISS;
         end
         OP_REMOVE: begin
            pos = locate_value(v);
            if (pos >= 0) begin
               r.found = 1'b1;
               close_gap(pos);
            end else begin
               r.status = ST_MISS;
            end
         end
         default: ;
      endcase
      if (shadow_held > 0) begin
         r.front_value = shadow_entries[0];
         r.back_value  = shadow_entries[shadow_held - 1];
      end
      r.entry_count = shadow_held[4:0];
      r.is_empty    = (shadow_held == 0);
      return r;
   endfunction

   function automatic rsp_payload_type make_rsp(logic [1:0] status, logic found,
                                                word_type front, word_type back,
                                                logic [4:0] count, logic empty);
      rsp_payload_type r;
      r.status      = status;
      r.found       = found;
      r.front_value = front;
      r.back_value  = back;
      r.entry_count = count;
      r.is_empty    = empty;
      return r;
   endfunction

   function automatic logic [2:0] pick_op(mix_type mix);
      int r;
      int push_lim;
      int pop_lim;
      r = $urandom_range(0, 99);
      case (mix)
         MIX_FILL:  begin push_lim = 52; pop_lim = 72; end
         MIX_DRAIN: begin push_lim = 26; pop_lim = 72; end
         default:   begin push_lim = 40; pop_lim = 66; end
      endcase
      if (r == 0) return OP_SPARE_6;
      if (r == 1) return OP_SPARE_7;
      if (r < push_lim) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      if (r < pop_lim) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      return $urandom_range(0, 1) ? OP_REMOVE : OP_CONTAINS;
   endfunction

   // Mostly pool values so that searches hit, otherwise any 32-bit word
   function automatic word_type pick_value();
      if ($urandom_range(0, 9) < 7) return value_pool[$urandom_range(0, 7)];
      return word_type'($urandom);
   endfunction

   task automatic add_row(logic [2:0] op, word_type value, int reps, bit pinned,
                          rsp_payload_type lit);
      stim_row_type row;
      row.op     = op;
      row.value  = value;
      row.reps   = reps;
      row.pinned = pinned;
      row.lit    = lit;
      stim_table.push_back(row);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // Present one request; entered and left at a falling edge
   task automatic send_item(logic [2:0] op, word_type value, bit pinned,
                            rsp_payload_type lit);
      int gap;
      literal_tag_type tag;
      tag.pinned = pinned;
      tag.rsp    = lit;
      literal_rsp_q.push_back(tag);
      gap = quiet_phase ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.data.operation <= op;
      req_ch.data.value     <= value;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      @(negedge clock);
   endtask

   // Response side: random back-pressure, plus one long hold on request
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end
         if (rsp_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Sample both channels at the rising edge: check responses, predict requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_rsp_q.size() == 0) begin
               $display("%0t: response with nothing outstanding: actual %h", $time, rsp_ch.data);
               error_count++;
            end else begin
               check_field("status", predicted_rsp_q[0].status, rsp_ch.data.status);
               check_field("found", predicted_rsp_q[0].found, rsp_ch.data.found);
               check_field("front_value", predicted_rsp_q[0].front_value,
                           rsp_ch.data.front_value);
               check_field("back_value", predicted_rsp_q[0].back_value,
                           rsp_ch.data.back_value);
               check_field("entry_count", predicted_rsp_q[0].entry_count,
                           rsp_ch.data.entry_count);
               check_field("is_empty", predicted_rsp_q[0].is_empty, rsp_ch.data.is_empty);
               void'(predicted_rsp_q.pop_front());
            end
            status_tally[rsp_ch.data.status]++;
            rsp_seen++;
            rsp_hold = quiet_phase ? 0 : $urandom_range(0, 5);
         end
         if (req_ch.valid && req_ch.ready) begin
            automatic rsp_payload_type pred = apply_deque_op(req_ch.data.operation,
                                                             req_ch.data.value);
            op_tally[req_ch.data.operation]++;
            if (shadow_held == DQ_DEPTH) full_hits++;
            if (literal_rsp_q.size() == 0) begin
               predicted_rsp_q.push_back(pred);
            end else begin
               predicted_rsp_q.push_back(literal_rsp_q[0].pinned ? literal_rsp_q[0].rsp : pred);
               void'(literal_rsp_q.pop_front());
            end
         end
      end
   end

   // Stimulus
   initial begin
      int n;
      int ops_issued;
      int k;
      logic [2:0] op;
      mix_type mix;

      error_count = 0;
      rsp_seen    = 0;
      full_hits   = 0;
      rsp_hold    = 0;
      quiet_phase = 1'b0;
      long_hold   = 1'b0;
      shadow_held = 0;
      foreach (shadow_entries[i]) shadow_entries[i] = '0;
      foreach (op_tally[i]) op_tally[i] = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.data    = '0;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed table: empty deque, extremes, spare codes, duplicates, full, drain
      add_row(OP_POP_FRONT, 32'sd0, 1, 1, make_rsp(ST_EMPTY, 0, 0, 0, 0, 1));
      add_row(OP_POP_BACK, 32'sd0, 1, 1, make_rsp(ST_EMPTY, 0, 0, 0, 0, 1));
      add_row(OP_CONTAINS, 32'sd0, 1, 1, make_rsp(ST_MISS, 0, 0, 0, 0, 1));
      add_row(OP_REMOVE, 32'sd5, 1, 1, make_rsp(ST_MISS, 0, 0, 0, 0, 1));
      add_row(OP_PUSH_BACK, WORD_MAX, 1, 1, make_rsp(ST_DONE, 0, WORD_MAX, WORD_MAX, 1, 0));
      add_row(OP_PUSH_FRONT, WORD_MIN, 1, 1, make_rsp(ST_DONE, 0, WORD_MIN, WORD_MAX, 2, 0));
      add_row(OP_CONTAINS, WORD_MIN, 1, 1, make_rsp(ST_DONE, 1, WORD_MIN, WORD_MAX, 2, 0));
      add_row(OP_CONTAINS, 32'sd0, 1, 1, make_rsp(ST_MISS, 0, WORD_MIN, WORD_MAX, 2, 0));
      add_row(OP_SPARE_6, -32'sd1, 1, 1, make_rsp(ST_DONE, 0, WORD_MIN, WORD_MAX, 2, 0));
      add_row(OP_SPARE_7, 32'sd0, 1, 1, make_rsp(ST_DONE, 0, WORD_MIN, WORD_MAX, 2, 0));
      add_row(OP_PUSH_BACK, 32'sd7, 1, 0, '0);
      add_row(OP_PUSH_BACK, 32'sd7, 1, 0, '0);
      add_row(OP_REMOVE, 32'sd7, 1, 0, '0);
      add_row(OP_PUSH_BACK, 32'sd100, 13, 0, '0);
      add_row(OP_PUSH_FRONT, 32'sd1, 1, 0, '0);
      add_row(OP_PUSH_BACK, 32'sd1, 1, 0, '0);
      add_row(OP_CONTAINS, 32'sd112, 1, 0, '0);
      add_row(OP_REMOVE, 32'sd106, 1, 0, '0);
      add_row(OP_REMOVE, WORD_MIN, 1, 0, '0);
      add_row(OP_REMOVE, 32'sd112, 1, 0, '0);
      add_row(OP_REMOVE, 32'sd106, 1, 0, '0);
      add_row(OP_POP_BACK, 32'sd0, 1, 0, '0);
      add_row(OP_POP_FRONT, -32'sd1, 16, 0, '0);
      add_row(OP_PUSH_FRONT, -32'sd1, 1, 0, '0);
      add_row(OP_POP_BACK, 32'sd0, 1, 1, make_rsp(ST_DONE, 0, 0, 0, 0, 1));

      foreach (stim_table[r]) begin
         for (k = 0; k < stim_table[r].reps; k++) begin
            send_item(stim_table[r].op, stim_table[r].value + k, stim_table[r].pinned,
                      stim_table[r].lit);
         end
      end

      // Let the directed part drain before the random part
      req_ch.valid <= 1'b0;
      while (predicted_rsp_q.size() != 0 || literal_rsp_q.size() != 0) @(negedge clock);

      // Random part in phases of differing push/pop mix and idling
      n = 0;
      ops_issued = 0;
      mix = MIX_EVEN;
      while (ops_issued < RANDOM_OPS) begin
         if (n % 150 == 0) begin
            mix = mix_type'($urandom_range(0, 2));
            quiet_phase = ($urandom_range(0, 3) == 0);
         end
         // Long response stall with requests still offered back to back
         if (n == 700) begin
            long_hold = 1'b1;
            quiet_phase = 1'b1;
         end
         // Sender pause until every outstanding response has come back
         if (n == 1200) begin
            req_ch.valid <= 1'b0;
            while (predicted_rsp_q.size() != 0 || literal_rsp_q.size() != 0)
               @(negedge clock);
         end
         op = pick_op(mix);
         send_item(op, pick_value(), 0, '0);
         if (op <= OP_REMOVE) ops_issued++;
         n++;
      end

      // Wind down
      req_ch.valid <= 1'b0;
      while (predicted_rsp_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);

      $display("Ran %0d responses: push %0d/%0d, pop %0d/%0d, contains %0d, remove %0d, spare %0d",
               rsp_seen, op_tally[OP_PUSH_FRONT], op_tally[OP_PUSH_BACK],
               op_tally[OP_POP_FRONT], op_tally[OP_POP_BACK], op_tally[OP_CONTAINS],
               op_tally[OP_REMOVE], op_tally[OP_SPARE_6] + op_tally[OP_SPARE_7]);
      $display("Status seen: done %0d, empty %0d, full %0d, miss %0d; full deque %0d times",
               status_tally[ST_DONE], status_tally[ST_EMPTY], status_tally[ST_FULL],
               status_tally[ST_MISS], full_hits);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
